/* rtl/primary_ray_direction_assert.svh */
// ----------------------------------------------------------------------------
// primary_ray_direction assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PRIMARY_RAY_DIRECTION_ASSERT_SVH
`define PRIMARY_RAY_DIRECTION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/prd_pkg.sv */
// ----------------------------------------------------------------------------
// prd_pkg
// Types and fixed constants of the primary ray direction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

    // Q1.16 output component
    localparam int OUT_W  = 18;
    // normalizer datapath widths
    localparam int NORM_W = 64;   // magnitude word before alignment
    localparam int NSHIFT = 6;    // alignment steps: 32,16,8,4,2,1
    localparam int MAG_W  = 30;   // aligned magnitude, top bit at 2^29
    localparam int SQ_W   = 62;   // sum of three squares
    localparam int ROOT_W = 31;   // floor(sqrt) width
    localparam int REM_W  = 33;   // root remainder width
    localparam int QDIV_W = 17;   // quotient bits, result <= 2^16
    localparam int FRAC_SH = 17;  // mag*2^17 for rounded divide
    localparam int DIVN_W = MAG_W + FRAC_SH + 1;
    localparam int LSH    = 10;   // Q.16 to Q.26
    localparam logic [QDIV_W-1:0] ONE_Q16 = 17'h10000;

    typedef logic signed [OUT_W-1:0] dir_t;

    // pipeline control between stages and units
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    typedef enum logic [2:0] {
        CFG_POSITION = 3'd0,
        CFG_TARGET   = 3'd1,
        CFG_RIGHT    = 3'd2,
        CFG_UP       = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } cfg_idx_t;

endpackage

`default_nettype wire

/* rtl/prd_offset.sv */
// ----------------------------------------------------------------------------
// prd_offset
// Pipelined screen offsets U and V: (2p+1-n)/(2n) in Q.16, rounded to
// nearest with ties away from zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_offset import prd_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire pipe_ctl_t                  ctl,
    input  wire logic [COORD_BITS-1:0]      p [2],
    input  wire logic [COORD_BITS:0]        n [2],
    output logic                            out_valid,
    output logic signed [COORD_BITS+16:0]   off [2]
);

    localparam int Q  = COORD_BITS + 16;     // quotient bits
    localparam int NW = COORD_BITS + 3;      // signed numerator
    localparam int AW = COORD_BITS + 2;      // numerator magnitude
    localparam int RW = 2 * COORD_BITS + 19; // partial remainder

    logic [RW-1:0] r_reg  [Q+1][2];
    logic [Q-1:0]  q_reg  [Q+1][2];
    logic [1:0]    neg_reg [Q+1];
    logic [Q:0]    v_reg;

    logic [RW-1:0] r_next [Q+1][2];
    logic [Q-1:0]  q_next [Q+1][2];
    logic [1:0]    neg_next [Q+1];

    // numerator setup then restoring divide by 4n
    always_comb begin
        logic signed [NW-1:0] num;
        logic [AW-1:0]        a;
        logic [RW-1:0]        sub;
        for (int k = 0; k < 2; k++) begin
            num = $signed({2'b00, p[k], 1'b1}) - $signed({2'b00, n[k]});
            a = num[NW-1] ? AW'(-num) : AW'(num);
            neg_next[0][k] = num[NW-1];
            r_next[0][k] = RW'({a, FRAC_SH'(0)}) + RW'({n[k], 1'b0});
            q_next[0][k] = '0;
        end
        for (int d = 0; d < Q; d++) begin
            neg_next[d+1] = neg_reg[d];
            for (int k = 0; k < 2; k++) begin
                sub = RW'({n[k], 2'b00}) << (Q - 1 - d);
                r_next[d+1][k] = r_reg[d][k];
                q_next[d+1][k] = q_reg[d][k];
                if (r_reg[d][k] >= sub) begin
                    r_next[d+1][k] = r_reg[d][k] - sub;
                    q_next[d+1][k][Q-1-d] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            r_reg   <= r_next;
            q_reg   <= q_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl.en) begin
            v_reg <= {v_reg[Q-1:0], ctl.valid};
        end
    end

    assign out_valid = v_reg[Q];

    // sign restore
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            off[k] = neg_reg[Q][k] ? -$signed({1'b0, q_reg[Q][k]})
                                   : $signed({1'b0, q_reg[Q][k]});
        end
    end

endmodule

`default_nettype wire

/* rtl/prd_norm.sv */
// ----------------------------------------------------------------------------
// prd_norm
// Pipelined normalizer of a signed three-vector into Q1.16: magnitude
// alignment, squares, digit-serial square root, then rounded divides.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_norm import prd_pkg::*; #(
    parameter int IN_W = 21
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire pipe_ctl_t              ctl,
    input  wire logic signed [IN_W-1:0] in_vec [3],
    output logic                        out_valid,
    output dir_t                        out_vec [3]
);

    localparam int SQ_N = ROOT_W;
    localparam int DV_N = QDIV_W;

    // alignment stages
    logic [NORM_W-1:0] sm_reg  [NSHIFT+1][3];
    logic [NORM_W-1:0] sm_next [NSHIFT+1][3];
    logic [2:0]        sn_reg  [NSHIFT+1];
    logic [2:0]        sn_next [NSHIFT+1];
    logic [NSHIFT:0]   sv_reg;

    // squares
    logic [MAG_W-1:0]   qa_next [3];
    logic [MAG_W-1:0]   qa_reg  [3];
    logic [2*MAG_W-1:0] qs_reg  [3];
    logic [2:0]         qn_reg;
    logic               qz_reg;
    logic               qv_reg;

    // square root stages
    logic [REM_W-1:0]  rr_reg  [SQ_N+1];
    logic [ROOT_W-1:0] rt_reg  [SQ_N+1];
    logic [SQ_W-1:0]   rs_reg  [SQ_N+1];
    logic [MAG_W-1:0]  ra_reg  [SQ_N+1][3];
    logic [2:0]        rn_reg  [SQ_N+1];
    logic [SQ_N:0]     rz_reg;
    logic [SQ_N:0]     rv_reg;
    logic [REM_W-1:0]  rr_next [SQ_N+1];
    logic [ROOT_W-1:0] rt_next [SQ_N+1];
    logic [SQ_W-1:0]   rs_next [SQ_N+1];
    logic [MAG_W-1:0]  ra_next [SQ_N+1][3];
    logic [2:0]        rn_next [SQ_N+1];
    logic [SQ_N:0]     rz_next;

    // divide stages
    logic [DIVN_W-1:0] dr_reg  [DV_N+1][3];
    logic [QDIV_W-1:0] dq_reg  [DV_N+1][3];
    logic [ROOT_W-1:0] dl_reg  [DV_N+1];
    logic [2:0]        dn_reg  [DV_N+1];
    logic [DV_N:0]     dz_reg;
    logic [DV_N:0]     dv_reg;
    logic [DIVN_W-1:0] dr_next [DV_N+1][3];
    logic [QDIV_W-1:0] dq_next [DV_N+1][3];
    logic [ROOT_W-1:0] dl_next [DV_N+1];
    logic [2:0]        dn_next [DV_N+1];
    logic [DV_N:0]     dz_next;

    dir_t out_reg [3];
    logic out_v_reg;

    // magnitudes and shared alignment of all three lanes
    always_comb begin
        logic [IN_W:0]     ext;
        logic [NORM_W-1:0] acc;
        for (int i = 0; i < 3; i++) begin
            ext = {in_vec[i][IN_W-1], in_vec[i]};
            sn_next[0][i] = ext[IN_W];
            if (ext[IN_W]) begin
                ext = -ext;
            end
            sm_next[0][i] = NORM_W'(ext);
        end
        for (int g = 0; g < NSHIFT; g++) begin
            acc = sm_reg[g][0] | sm_reg[g][1] | sm_reg[g][2];
            sn_next[g+1] = sn_reg[g];
            for (int i = 0; i < 3; i++) begin
                sm_next[g+1][i] = ((acc >> (NORM_W - (32 >> g))) == '0)
                                ? (sm_reg[g][i] << (32 >> g)) : sm_reg[g][i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            sm_reg <= sm_next;
            sn_reg <= sn_next;
        end
    end

    // aligned magnitude: largest lane lands in [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qa_next[i] = sm_reg[NSHIFT][i][NORM_W-1 -: MAG_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                qa_reg[i] <= qa_next[i];
                qs_reg[i] <= qa_next[i] * qa_next[i];
            end
            qn_reg <= sn_reg[NSHIFT];
            qz_reg <= |(qa_next[0] | qa_next[1] | qa_next[2]);
        end
    end

    // sum of squares, then one root bit per stage
    always_comb begin
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] t;
        rr_next[0] = '0;
        rt_next[0] = '0;
        rs_next[0] = SQ_W'(qs_reg[0]) + SQ_W'(qs_reg[1]) + SQ_W'(qs_reg[2]);
        ra_next[0] = qa_reg;
        rn_next[0] = qn_reg;
        rz_next[0] = qz_reg;
        for (int j = 0; j < SQ_N; j++) begin
            trial = {rr_reg[j], rs_reg[j][SQ_W-1 -: 2]};
            t = (REM_W+2)'({rt_reg[j], 2'b01});
            if (trial >= t) begin
                rr_next[j+1] = REM_W'(trial - t);
                rt_next[j+1] = {rt_reg[j][ROOT_W-2:0], 1'b1};
            end else begin
                rr_next[j+1] = REM_W'(trial);
                rt_next[j+1] = {rt_reg[j][ROOT_W-2:0], 1'b0};
            end
            rs_next[j+1] = rs_reg[j] << 2;
            ra_next[j+1] = ra_reg[j];
            rn_next[j+1] = rn_reg[j];
            rz_next[j+1] = rz_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rr_reg <= rr_next;
            rt_reg <= rt_next;
            rs_reg <= rs_next;
            ra_reg <= ra_next;
            rn_reg <= rn_next;
            rz_reg <= rz_next;
        end
    end

    // q = (mag*2^17 + len) / (2*len), one quotient bit per stage
    always_comb begin
        logic [DIVN_W:0] sub;
        dl_next[0] = rt_reg[SQ_N];
        dn_next[0] = rn_reg[SQ_N];
        dz_next[0] = rz_reg[SQ_N];
        for (int i = 0; i < 3; i++) begin
            dr_next[0][i] = DIVN_W'({ra_reg[SQ_N][i], FRAC_SH'(0)})
                          + DIVN_W'(rt_reg[SQ_N]);
            dq_next[0][i] = '0;
        end
        for (int d = 0; d < DV_N; d++) begin
            dl_next[d+1] = dl_reg[d];
            dn_next[d+1] = dn_reg[d];
            dz_next[d+1] = dz_reg[d];
            sub = (DIVN_W+1)'({dl_reg[d], 1'b0}) << (DV_N - 1 - d);
            for (int i = 0; i < 3; i++) begin
                dr_next[d+1][i] = dr_reg[d][i];
                dq_next[d+1][i] = dq_reg[d][i];
                if ({1'b0, dr_reg[d][i]} >= sub) begin
                    dr_next[d+1][i] = DIVN_W'({1'b0, dr_reg[d][i]} - sub);
                    dq_next[d+1][i][DV_N-1-d] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            dr_reg <= dr_next;
            dq_reg <= dq_next;
            dl_reg <= dl_next;
            dn_reg <= dn_next;
            dz_reg <= dz_next;
        end
    end

    // clamp, restore sign, zero vector gives zero
    always_ff @(posedge aclk) begin
        logic [QDIV_W-1:0] qc;
        if (ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                qc = (dq_reg[DV_N][i] > ONE_Q16) ? ONE_Q16 : dq_reg[DV_N][i];
                if (!dz_reg[DV_N]) begin
                    out_reg[i] <= '0;
                end else if (dn_reg[DV_N][i]) begin
                    out_reg[i] <= -$signed({1'b0, qc});
                end else begin
                    out_reg[i] <= $signed({1'b0, qc});
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg    <= '0;
            qv_reg    <= 1'b0;
            rv_reg    <= '0;
            dv_reg    <= '0;
            out_v_reg <= 1'b0;
        end else if (ctl.en) begin
            sv_reg    <= {sv_reg[NSHIFT-1:0], ctl.valid};
            qv_reg    <= sv_reg[NSHIFT];
            rv_reg    <= {rv_reg[SQ_N-1:0], qv_reg};
            dv_reg    <= {dv_reg[DV_N-1:0], rv_reg[SQ_N]};
            out_v_reg <= dv_reg[DV_N];
        end
    end

    assign out_valid = out_v_reg;
    assign out_vec   = out_reg;

endmodule

`default_nettype wire

/* rtl/primary_ray_direction.sv */
// ----------------------------------------------------------------------------
// primary_ray_direction
// Pinhole camera primary ray generator: pixel in, unit Q1.16 direction out.
// ----------------------------------------------------------------------------
// One pixel beat is taken per clock while s_tready is high, and one
// direction beat leaves per pixel, in order. The path runs through
// COORD_BITS+17 stages of the screen offset divider, two stages of
// products and sums, 59 stages of the normalizer, whose 32-stage square
// root and 18-stage divide make up most of them, and the output buffer.
// A two-entry output buffer lets the pipe keep
// taking pixels while a result waits; when it is full the pipe holds.
// Any camera register write starts a recompute of the unit view vector
// through a second normalizer; s_tready stays low after the last write
// until it is done.
`default_nettype none

module primary_ray_direction import prd_pkg::*; #(
    parameter int COORD_BITS     = 12,
    parameter int COMPONENT_BITS = 20
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // pixel_x, pixel_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // dir_x, dir_y, dir_z
    output logic [((3*OUT_W+7)/8)*8-1:0]               m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // register write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [2:0]                            cfg_index,
    input  wire logic [3*COMPONENT_BITS-1:0]           cfg_data
);

    localparam int CW   = COMPONENT_BITS;
    localparam int VW   = 3 * CW;
    localparam int DIMW = COORD_BITS + 1;
    localparam int OW   = COORD_BITS + 17;
    localparam int PW   = CW + OW;
    localparam int DW   = PW + 2;
    localparam int MW   = ((3*OUT_W+7)/8)*8;
    localparam int LW   = OUT_W + LSH;
    localparam int OBW  = 3 * OUT_W;

    logic [VW-1:0]   pos_reg, tgt_reg, right_reg, up_reg;
    logic [DIMW-1:0] width_reg, height_reg;

    logic            kick_reg;
    logic [6:0]      lcnt_reg;
    dir_t            l_reg [3];
    logic            busy;

    logic            en;
    logic [1:0]      fifo_cnt_reg;
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [OBW-1:0]  fifo_mem [2];

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            tgt_reg    <= '0;
            right_reg  <= '0;
            up_reg     <= '0;
            width_reg  <= DIMW'(640);
            height_reg <= DIMW'(480);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_POSITION: pos_reg    <= cfg_data;
                CFG_TARGET:   tgt_reg    <= cfg_data;
                CFG_RIGHT:    right_reg  <= cfg_data;
                CFG_UP:       up_reg     <= cfg_data;
                CFG_WIDTH:    width_reg  <= cfg_data[DIMW-1:0];
                CFG_HEIGHT:   height_reg <= cfg_data[DIMW-1:0];
                default:      ;
            endcase
        end
    end

    // view vector recompute after writes
    logic signed [CW:0]  diff [3];
    pipe_ctl_t           lctl;
    logic                l_out_valid;
    dir_t                l_out [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = $signed({tgt_reg[i*CW+CW-1], tgt_reg[i*CW +: CW]})
                    - $signed({pos_reg[i*CW+CW-1], pos_reg[i*CW +: CW]});
        end
    end

    assign lctl = '{en: 1'b1, valid: kick_reg};

    prd_norm #(.IN_W(CW + 1)) u_view_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (lctl),
        .in_vec    (diff),
        .out_valid (l_out_valid),
        .out_vec   (l_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_reg <= 1'b0;
            lcnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                l_reg[i] <= '0;
            end
        end else begin
            kick_reg <= cfg_valid && cfg_ready;
            lcnt_reg <= lcnt_reg + 7'(kick_reg) - 7'(l_out_valid);
            if (l_out_valid) begin
                l_reg <= l_out;
            end
        end
    end

    assign busy     = kick_reg || (lcnt_reg != '0);
    assign en       = (fifo_cnt_reg != 2'd2);
    assign s_tready = en && !busy;

    // screen offsets
    pipe_ctl_t                 octl;
    logic [COORD_BITS-1:0]     pix [2];
    logic [DIMW-1:0]           dim [2];
    logic                      off_valid;
    logic signed [OW-1:0]      off [2];

    assign octl   = '{en: en, valid: s_tvalid && s_tready};
    assign pix[0] = s_tdata[COORD_BITS-1:0];
    assign pix[1] = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign dim[0] = (width_reg == '0) ? DIMW'(1) : width_reg;
    assign dim[1] = (height_reg == '0) ? DIMW'(1) : height_reg;

    prd_offset #(.COORD_BITS(COORD_BITS)) u_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (octl),
        .p         (pix),
        .n         (dim),
        .out_valid (off_valid),
        .off       (off)
    );

    // right*U and up*V products
    logic signed [PW-1:0] pr_reg [3];
    logic signed [PW-1:0] pu_reg [3];
    logic                 mv_reg;
    logic signed [DW-1:0] d_reg [3];
    logic                 dv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pr_reg[i] <= $signed(right_reg[i*CW +: CW]) * off[0];
                pu_reg[i] <= $signed(up_reg[i*CW +: CW]) * off[1];
            end
        end
    end

    // D in Q.26
    always_ff @(posedge aclk) begin
        logic signed [LW-1:0] lt;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                lt = $signed({l_reg[i], LSH'(0)});
                d_reg[i] <= DW'(pr_reg[i]) + DW'(pu_reg[i]) + DW'(lt);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
            dv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= off_valid;
            dv_reg <= mv_reg;
        end
    end

    // final normalize
    pipe_ctl_t nctl;
    logic      n_valid;
    dir_t      n_out [3];

    assign nctl = '{en: en, valid: dv_reg};

    prd_norm #(.IN_W(DW)) u_dir_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (nctl),
        .in_vec    (d_reg),
        .out_valid (n_valid),
        .out_vec   (n_out)
    );

    // two-entry output buffer
    logic push, pop;
    assign push = n_valid && en;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {n_out[2], n_out[1], n_out[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_cnt_reg <= '0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fifo_cnt_reg <= fifo_cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = MW'(fifo_mem[rd_ptr_reg]);

`include "primary_ray_direction_assert.svh"

    `PRD_ASSERT_NEXT(a_cfg_holds_input, cfg_valid && cfg_ready, !s_tready, "input open after write")
    `PRD_ASSERT_SAME(a_full_holds_input, fifo_cnt_reg == 2'd2, !s_tready, "input open while full")
    `PRD_ASSERT_SAME(a_view_result_owed, l_out_valid, lcnt_reg != '0, "unexpected view result")

endmodule

`default_nettype wire
